// ===== design/mlgs_pkg.sv =====
// shared constants, types and cross-mask helpers for the masked life grid stepper
package mlgs_pkg;

  // grid geometry: three by three panels
  localparam int unsigned PANEL_SIZE = 8;
  localparam int unsigned GRID_SIZE  = 3 * PANEL_SIZE;
  localparam int unsigned IDX_W      = $clog2(GRID_SIZE);

  // display level of a live cell
  localparam logic [2:0] LEVEL_ON = 3'd7;

  // request opcodes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // per-row control handed to each row cell
  typedef struct packed {
    logic             wr;
    logic             adv;
    logic [IDX_W-1:0] col;
    logic             alive;
  } cell_ctrl_t;

  // true when (r, c) is inside the grid and inside the plus-shaped panel set
  function automatic logic in_cross(input int unsigned r, input int unsigned c);
    int unsigned pr;
    int unsigned pc;
    logic        res;
    pr  = r / PANEL_SIZE;
    pc  = c / PANEL_SIZE;
    res = 1'b0;
    if (r < GRID_SIZE && c < GRID_SIZE) begin
      res = (pr == 1) || (pc == 1);
    end
    return res;
  endfunction

  // usable columns of one row
  function automatic logic [GRID_SIZE-1:0] row_mask(input int unsigned r);
    logic [GRID_SIZE-1:0] m;
    m = '0;
    for (int unsigned c = 0; c < GRID_SIZE; c++) begin
      m[c] = in_cross(r, c);
    end
    return m;
  endfunction

endpackage

// ===== design/masked_life_grid_stepper_core.sv =====
// masked life grid stepper: chain of row cells, request decode and result register
// an accepted request has its result in the output register in the cycle after it is accepted
// throughput: one request per cycle while the input is not stalled; a whole generation is computed
//   at once, every row cell counting its neighbors from the rows above and below in parallel
// input is stalled only while a result waits and the output side stalls
// reset clears every grid cell to dead and empties the result register
module masked_life_grid_stepper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [4:0] row_i,
  input  logic [4:0] col_i,
  input  logic       alive_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] level_o,
  output logic       usable_o
);

  localparam int unsigned GridW = mlgs_pkg::GRID_SIZE;
  localparam int unsigned IdxW  = mlgs_pkg::IDX_W;

  logic                  in_acc;
  logic                  addr_ok;
  logic [IdxW-1:0]       row_idx;
  logic [IdxW-1:0]       col_idx;
  logic                  rd_bit;
  logic                  is_write;
  logic                  is_adv;
  logic                  is_read;
  logic [GridW-1:0]      rows [GridW];
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [2:0]            level_q;
  logic [2:0]            level_d;
  logic                  usable_q;
  logic                  usable_d;

  // handshake: accept while the result register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // request decode
  assign addr_ok  = mlgs_pkg::in_cross(32'(row_i), 32'(col_i));
  assign row_idx  = IdxW'(row_i);
  assign col_idx  = IdxW'(col_i);
  assign is_write = in_acc & (op_i == mlgs_pkg::OP_WRITE);
  assign is_adv   = in_acc & (op_i == mlgs_pkg::OP_ADVANCE);
  assign is_read  = (op_i == mlgs_pkg::OP_READ);

  // chain of row cells, each fed by its neighbor rows
  for (genvar r = 0; r < GridW; r++) begin : g_rows
    mlgs_pkg::cell_ctrl_t   ctrl;
    logic [GridW-1:0]       up_row;
    logic [GridW-1:0]       dn_row;

    assign ctrl.wr    = is_write & addr_ok & (row_idx == IdxW'(r));
    assign ctrl.adv   = is_adv;
    assign ctrl.col   = col_idx;
    assign ctrl.alive = alive_i;

    if (r == 0) begin : g_top
      assign up_row = '0;
    end else begin : g_up
      assign up_row = rows[r-1];
    end
    if (r == GridW - 1) begin : g_bot
      assign dn_row = '0;
    end else begin : g_dn
      assign dn_row = rows[r+1];
    end

    mlgs_row_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .mask_i (mlgs_pkg::row_mask(r)),
      .up_i   (up_row),
      .dn_i   (dn_row),
      .row_o  (rows[r])
    );
  end

  // read port into the addressed row
  assign rd_bit = addr_ok & rows[row_idx][col_idx];

  // result for the accepted request
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    level_d     = level_q;
    usable_d    = usable_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      level_d     = (is_read & rd_bit) ? mlgs_pkg::LEVEL_ON : 3'd0;
      usable_d    = addr_ok & ((op_i == mlgs_pkg::OP_WRITE) | is_read);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    usable_q <= usable_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign usable_o    = usable_q;

`ifndef SYNTHESIS
  // a lit level only comes from a usable cell
  a_level_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && level_q != 3'd0) |-> usable_q)
    else $error("level set on unusable cell");

  // a generation step answers with an all-zero result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_adv |=> (out_valid_q && level_q == 3'd0 && !usable_q))
    else $error("bad result for generation step");

  // a read returns the stored cell
  a_read_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=>
      (level_q == ($past(rd_bit) ? mlgs_pkg::LEVEL_ON : 3'd0)))
    else $error("read returned wrong level");
`endif

endmodule

// ===== design/mlgs_row_cell.sv =====
// one row cell: holds a grid row and computes its next generation from its neighbors
module mlgs_row_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mlgs_pkg::cell_ctrl_t           ctrl_i,
  input  logic [mlgs_pkg::GRID_SIZE-1:0] mask_i,
  input  logic [mlgs_pkg::GRID_SIZE-1:0] up_i,
  input  logic [mlgs_pkg::GRID_SIZE-1:0] dn_i,
  output logic [mlgs_pkg::GRID_SIZE-1:0] row_o
);

  logic [mlgs_pkg::GRID_SIZE-1:0] row_q;
  logic [mlgs_pkg::GRID_SIZE-1:0] row_d;
  logic [mlgs_pkg::GRID_SIZE-1:0] next_gen;
  logic [mlgs_pkg::GRID_SIZE+1:0] up_p;
  logic [mlgs_pkg::GRID_SIZE+1:0] mid_p;
  logic [mlgs_pkg::GRID_SIZE+1:0] dn_p;
  logic [3:0]                     nbr_cnt [mlgs_pkg::GRID_SIZE];

  // zero-padded neighbor rows so the grid edge reads as dead
  assign up_p  = {1'b0, up_i, 1'b0};
  assign mid_p = {1'b0, row_q, 1'b0};
  assign dn_p  = {1'b0, dn_i, 1'b0};

  // per-column neighbor counter and life rule
  always_comb begin
    for (int c = 0; c < mlgs_pkg::GRID_SIZE; c++) begin
      nbr_cnt[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                 + 4'(mid_p[c]) + 4'(mid_p[c+2])
                 + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      next_gen[c] = mask_i[c] & ((nbr_cnt[c] == 4'd3) | (row_q[c] & (nbr_cnt[c] == 4'd2)));
    end
  end

  // next row value: generation step or single-cell write
  always_comb begin
    row_d = row_q;
    if (ctrl_i.adv) begin
      row_d = next_gen;
    end else if (ctrl_i.wr) begin
      row_d[ctrl_i.col] = ctrl_i.alive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

`ifndef SYNTHESIS
  // cells outside the cross never come alive
  a_outside_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q & ~mask_i) == '0)
    else $error("live cell outside the cross");

  // without a write or a step the row holds
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl_i.wr && !ctrl_i.adv) |=> $stable(row_q))
    else $error("row changed without a request");

  // a write lands on the addressed column
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr && !ctrl_i.adv) |=> row_q[$past(ctrl_i.col)] == $past(ctrl_i.alive))
    else $error("write did not land");
`endif

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the masked life grid stepper core
module testbench;

  // op code with no function in the block
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0] level;
    logic       usable;
  } cell_result_t;

  // grid predictor and queue of expected results
  class life_scoreboard;
    logic [mlgs_pkg::GRID_SIZE-1:0] cells [mlgs_pkg::GRID_SIZE];
    cell_result_t                   expected_q [$];
    int                             errors;

    function new();
      foreach (cells[r]) cells[r] = '0;
      errors = 0;
    endfunction

    function bit on_cross(int r, int c);
      if (r < 0 || c < 0 || r >= mlgs_pkg::GRID_SIZE || c >= mlgs_pkg::GRID_SIZE)
        return 1'b0;
      return (r / int'(mlgs_pkg::PANEL_SIZE) == 1) || (c / int'(mlgs_pkg::PANEL_SIZE) == 1);
    endfunction

    function bit alive_at(int r, int c);
      if (!on_cross(r, c)) return 1'b0;
      return cells[r][c];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // update the grid for an accepted request and queue its result
    function void note_request(logic [1:0] op, logic [4:0] row, logic [4:0] col,
                               logic alive);
      logic [mlgs_pkg::GRID_SIZE-1:0] next_cells [mlgs_pkg::GRID_SIZE];
      cell_result_t                   res;
      int                             n;
      bit                             hit;
      res = '0;
      hit = on_cross(row, col);
      case (op)
        mlgs_pkg::OP_WRITE: begin
          res.usable = hit;
          if (hit) cells[row][col] = alive;
        end
        mlgs_pkg::OP_ADVANCE: begin
          for (int r = 0; r < mlgs_pkg::GRID_SIZE; r++) begin
            next_cells[r] = '0;
            for (int c = 0; c < mlgs_pkg::GRID_SIZE; c++) begin
              if (on_cross(r, c)) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++)
                    if ((dr != 0 || dc != 0) && alive_at(r + dr, c + dc)) n++;
                next_cells[r][c] = alive_at(r, c) ? (n == 2 || n == 3) : (n == 3);
              end
            end
          end
          cells = next_cells;
        end
        mlgs_pkg::OP_READ: begin
          res.usable = hit;
          if (hit && cells[row][col]) res.level = mlgs_pkg::LEVEL_ON;
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(logic [2:0] level, logic usable);
      cell_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: level %0d usable %0b", level, usable);
        return;
      end
      want = expected_q.pop_front();
      if (level !== want.level || usable !== want.usable) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected level %0d usable %0b, got level %0d usable %0b",
                   want.level, want.usable, level, usable);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] op_i = mlgs_pkg::OP_WRITE;
  logic [4:0] row_i = '0;
  logic [4:0] col_i = '0;
  logic       alive_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] level_o;
  logic       usable_o;

  life_scoreboard sb = new();
  int  sent = 0;
  int  accepted = 0;
  bit  no_idle = 1'b0;
  bit  drain = 1'b0;

  masked_life_grid_stepper_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .alive_i     (alive_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .usable_o    (usable_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // request and result monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_request(op_i, row_i, col_i, alive_i);
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(level_o, usable_o);
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(input logic [1:0] op, input int row, input int col,
                              input logic alive);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= row[4:0];
    col_i      <= col[4:0];
    alive_i    <= alive;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // coordinate near a center, kept in the 5-bit range
  function automatic int near(int v);
    int p;
    p = v + $urandom_range(0, 4) - 2;
    return (p < 0) ? 0 : p;
  endfunction

  // seed a small window inside the cross, then step and read it
  task automatic seed_and_run();
    int pr;
    int pc;
    int cr;
    int cc;
    int steps;
    case ($urandom_range(0, 4))
      0: begin pr = 0; pc = 1; end
      1: begin pr = 1; pc = 0; end
      2: begin pr = 1; pc = 1; end
      3: begin pr = 1; pc = 2; end
      default: begin pr = 2; pc = 1; end
    endcase
    cr = pr * mlgs_pkg::PANEL_SIZE + $urandom_range(0, mlgs_pkg::PANEL_SIZE - 1);
    cc = pc * mlgs_pkg::PANEL_SIZE + $urandom_range(0, mlgs_pkg::PANEL_SIZE - 1);
    repeat ($urandom_range(3, 10))
      send_request(mlgs_pkg::OP_WRITE, near(cr), near(cc), $urandom_range(0, 3) != 0);
    steps = $urandom_range(1, 4);
    repeat (steps) begin
      send_request(mlgs_pkg::OP_ADVANCE, $urandom_range(0, 31), $urandom_range(0, 31),
                   1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4))
        send_request(mlgs_pkg::OP_READ, near(cr), near(cc), 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: random stalls, one long hold-off once traffic is going
  initial begin
    int  stall_left;
    int  free_left;
    bit  hold_done;
    stall_left = 0;
    free_left  = 0;
    hold_done  = 1'b0;
    @(posedge clk_i);
    forever begin
      if (stall_left == 0 && free_left == 0) begin
        stall_left = pick_gap();
        free_left  = no_idle ? 1 : $urandom_range(0, 8);
        if (!hold_done && accepted >= 150) begin
          stall_left = 300;
          hold_done  = 1'b1;
        end
      end
      if (stall_left > 0 && !drain) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = 0;
        if (free_left > 0) free_left--;
      end
      @(posedge clk_i);
    end
  end

  // stimulus and final verdict
  initial begin
    int guard;
    int failures;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the cross panels
    send_request(mlgs_pkg::OP_WRITE, 8, 0, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 0, 8, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 15, 23, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 23, 15, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 8, 8, 1'b1);
    // writes outside the cross or the grid are dropped, then reads and a spare op code
    send_request(mlgs_pkg::OP_WRITE, 0, 0, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 23, 23, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 7, 7, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 24, 8, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 31, 31, 1'b1);
    send_request(mlgs_pkg::OP_READ, 0, 0, 1'b0);
    send_request(mlgs_pkg::OP_READ, 8, 0, 1'b0);
    send_request(mlgs_pkg::OP_READ, 23, 15, 1'b0);
    send_request(mlgs_pkg::OP_READ, 7, 7, 1'b0);
    send_request(mlgs_pkg::OP_READ, 31, 31, 1'b1);
    send_request(mlgs_pkg::OP_READ, 8, 24, 1'b0);
    send_request(OP_SPARE, 31, 31, 1'b1);
    // blinker in the center panel
    send_request(mlgs_pkg::OP_WRITE, 11, 10, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 11, 11, 1'b1);
    send_request(mlgs_pkg::OP_WRITE, 11, 12, 1'b1);
    send_request(mlgs_pkg::OP_ADVANCE, 0, 0, 1'b0);
    send_request(mlgs_pkg::OP_READ, 10, 11, 1'b0);
    send_request(mlgs_pkg::OP_READ, 12, 11, 1'b0);
    send_request(mlgs_pkg::OP_READ, 11, 10, 1'b0);
    send_request(mlgs_pkg::OP_ADVANCE, 31, 31, 1'b1);
    send_request(mlgs_pkg::OP_READ, 11, 12, 1'b0);

    // random part: mostly seeded windows, some noise
    while (sent < 1400) begin
      no_idle = (sent >= 600 && sent < 800);
      if ($urandom_range(0, 9) < 7) seed_and_run();
      else send_request(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                        $urandom_range(0, 31), 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;
    drain = 1'b1;

    // wait for outstanding results, then idle before the verdict
    guard = 0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);

    failures = sb.errors + sb.pending();
    if (failures == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
design/mlgs_pkg.sv
design/mlgs_row_cell.sv
design/masked_life_grid_stepper_core.sv
verif/testbench.sv
